### rtl/core/tjca_pkg.sv
// Shared constants, a type and a step function for the track and jet closest approach block.
package tjca_pkg;

  localparam int COORD_BITS = 24;
  localparam int OUT_BITS   = 32;
  localparam int DIST_BITS  = 31;
  localparam int LIMIT_BITS = 31;

  // Iteration counts of the pipelined square root and divider sections.
  localparam int NRM_SQ_STEPS  = 31;
  localparam int NRM_DIV_STEPS = 31;
  localparam int PAR_DIV_STEPS = 32;
  localparam int DST_SQ_STEPS  = 32;

  // Edges from an accepted start to the edge that takes the result.
  localparam int TJCA_LATENCY = 4 + (NRM_SQ_STEPS + 1) + (NRM_DIV_STEPS + 1) + 6 +
                                (PAR_DIV_STEPS + 1) + 5 + (DST_SQ_STEPS + 1) + 1;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sqrt_t;

  // One step of the digit-by-digit integer square root.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [63:0] bitv);
    sqrt_t       o;
    logic [63:0] t;
    t = s.r + bitv;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

### rtl/core/track_jet_closest_approach_top.sv
// Top level of the pipelined closest approach between a track line and a jet line.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  input   | in        | start / busy         | in_first_*, in_last_*, in_jet_p*
//  result  | out       | out_strobe           | out_pca_*, out_min_distance, out_degenerate
//  config  | in        | cfg_we               | cfg_wdata (parallel limit)
//
// The block takes one beat in every cycle and returns the results in beat order.
// Most of its depth is set by the four bit-per-stage units in the datapath: the two
// direction norm square roots, the six direction divisions, the two line parameter
// divisions and the final distance square root.
// Reset is synchronous and active low; it clears the valid bits of every stage and sets
// the parallel limit to one. Since the receiver cannot stall, busy stays low and nothing
// in the pipeline ever waits.
module track_jet_closest_approach_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_first_x,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_first_y,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_first_z,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_last_x,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_last_y,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_last_z,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_jet_px,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_jet_py,
  input  logic signed [tjca_pkg::COORD_BITS-1:0] in_jet_pz,
  input  logic                                cfg_we,
  input  logic [tjca_pkg::LIMIT_BITS-1:0]     cfg_wdata,
  output logic                                out_strobe,
  output logic signed [tjca_pkg::OUT_BITS-1:0] out_pca_x,
  output logic signed [tjca_pkg::OUT_BITS-1:0] out_pca_y,
  output logic signed [tjca_pkg::OUT_BITS-1:0] out_pca_z,
  output logic [tjca_pkg::DIST_BITS-1:0]      out_min_distance,
  output logic                                out_degenerate
);
  import tjca_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int MW  = CB + 1;             // magnitude of a track difference
  localparam int PW  = $clog2(MW);         // bit position within a magnitude
  localparam int AW  = CB + 4;             // a and b dot products
  localparam int NW  = 32 + AW + 1;        // numerators of u and t
  localparam int PDW = (NW >= 64) ? NW : 64;

  typedef struct packed {
    logic [2:0][CB-1:0] p0;
    logic [5:0][29:0]   nmag;
    logic [5:0]         neg;
    logic               okt;
    logic               okj;
  } sa_side_t;

  typedef struct packed {
    logic [2:0][CB-1:0] p0;
    logic [5:0]         neg;
    logic               okt;
    logic               okj;
    logic [1:0][30:0]   n;
  } da_side_t;

  typedef struct packed {
    logic [2:0][CB-1:0] p0;
    logic [2:0][31:0]   dt;
    logic [2:0][31:0]   dj;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic        deg;
    logic [30:0] den;
    logic [1:0]  neg;
    logic        ovf_u;
    logic        ovf_t;
  } db_side_t;

  typedef struct packed {
    logic [2:0][CB-1:0] p0;
    logic [2:0][31:0]   pca;
    logic               far;
    logic               deg;
  } sd_side_t;

  function automatic logic [MW-1:0] max3(logic [MW-1:0] a, logic [MW-1:0] b,
                                         logic [MW-1:0] c);
    logic [MW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PW-1:0] msb_pos(logic [MW-1:0] m);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (m[i]) p = PW'(i);
    end
    return p;
  endfunction

  // Scales a magnitude by the power of two that brings the largest one to [2^29, 2^30).
  function automatic logic [29:0] norm_mag(logic [MW-1:0] mag, logic [PW-1:0] pos);
    logic [MW+29:0] w;
    if (pos >= 29) begin
      w = (MW + 30)'(mag) >> (pos - 29);
    end else begin
      w = (MW + 30)'(mag) << (29 - pos);
    end
    return w[29:0];
  endfunction

  // ---------------------------------------------------------------------------------
  // Configuration and handshake.
  // ---------------------------------------------------------------------------------
  logic [LIMIT_BITS-1:0] cfg_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= LIMIT_BITS'(1);
    end else if (cfg_we) begin
      cfg_limit_r <= cfg_wdata;
    end
  end

  // Every stage moves on every cycle, so a new beat is always welcome.
  assign busy = 1'b0;

  logic signed [CB-1:0] first_a [3];
  logic signed [CB-1:0] last_a  [3];
  logic signed [CB-1:0] jet_a   [3];

  assign first_a[0] = in_first_x;
  assign first_a[1] = in_first_y;
  assign first_a[2] = in_first_z;
  assign last_a[0]  = in_last_x;
  assign last_a[1]  = in_last_y;
  assign last_a[2]  = in_last_z;
  assign jet_a[0]   = in_jet_px;
  assign jet_a[1]   = in_jet_py;
  assign jet_a[2]   = in_jet_pz;

  // ---------------------------------------------------------------------------------
  // Front: track direction, magnitudes, normalizing shift and squares.
  // ---------------------------------------------------------------------------------
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [CB-1:0] s1_p0_r [3];
  logic signed [MW-1:0] s1_vec_r [6];
  logic [2:0][CB-1:0]   s2_p0_r, s3_p0_r, s4_p0_r;
  logic [MW-1:0]        s2_mag_r [6];
  logic [5:0]           s2_neg_r, s3_neg_r, s4_neg_r;
  logic [MW-1:0]        s2_mt_r, s2_mj_r;
  logic [29:0]          s3_nmag_r [6];
  logic [5:0][29:0]     s4_nmag_r;
  logic                 s3_okt_r, s3_okj_r, s4_okt_r, s4_okj_r;
  logic [59:0]          s4_sq_r [6];
  logic [MW-1:0]        mag_c [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag_c[i] = s1_vec_r[i][MW-1] ? MW'(-s1_vec_r[i]) : MW'(s1_vec_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_p0_r[i]      <= first_a[i];
      s1_vec_r[i]     <= MW'(last_a[i]) - MW'(first_a[i]);
      s1_vec_r[3 + i] <= MW'(jet_a[i]);
      s2_p0_r[i]      <= s1_p0_r[i];
    end
    for (int i = 0; i < 6; i++) begin
      s2_mag_r[i] <= mag_c[i];
      s2_neg_r[i] <= s1_vec_r[i][MW-1];
    end
    s2_mt_r <= max3(mag_c[0], mag_c[1], mag_c[2]);
    s2_mj_r <= max3(mag_c[3], mag_c[4], mag_c[5]);

    for (int i = 0; i < 3; i++) begin
      s3_nmag_r[i]     <= norm_mag(s2_mag_r[i], msb_pos(s2_mt_r));
      s3_nmag_r[3 + i] <= norm_mag(s2_mag_r[3 + i], msb_pos(s2_mj_r));
    end
    s3_okt_r <= (s2_mt_r != '0);
    s3_okj_r <= (s2_mj_r != '0);
    s3_neg_r <= s2_neg_r;
    s3_p0_r  <= s2_p0_r;

    for (int i = 0; i < 6; i++) begin
      s4_sq_r[i]   <= s3_nmag_r[i] * s3_nmag_r[i];
      s4_nmag_r[i] <= s3_nmag_r[i];
    end
    s4_neg_r <= s3_neg_r;
    s4_okt_r <= s3_okt_r;
    s4_okj_r <= s3_okj_r;
    s4_p0_r  <= s3_p0_r;
  end

  // ---------------------------------------------------------------------------------
  // Norms of the two directions: one root bit per stage.
  // ---------------------------------------------------------------------------------
  logic     sa_v_r [0:NRM_SQ_STEPS];
  sqrt_t    sa_q_r [0:NRM_SQ_STEPS][2];
  sa_side_t sa_s_r [0:NRM_SQ_STEPS];

  always_ff @(posedge clk) begin
    sa_q_r[0][0].x <= 64'(s4_sq_r[0]) + 64'(s4_sq_r[1]) + 64'(s4_sq_r[2]);
    sa_q_r[0][1].x <= 64'(s4_sq_r[3]) + 64'(s4_sq_r[4]) + 64'(s4_sq_r[5]);
    sa_q_r[0][0].r <= '0;
    sa_q_r[0][1].r <= '0;
    sa_s_r[0].p0   <= s4_p0_r;
    sa_s_r[0].nmag <= s4_nmag_r;
    sa_s_r[0].neg  <= s4_neg_r;
    sa_s_r[0].okt  <= s4_okt_r;
    sa_s_r[0].okj  <= s4_okj_r;
  end

  for (genvar k = 0; k < NRM_SQ_STEPS; k++) begin : g_nsq
    localparam logic [63:0] BITV = 64'(1) << (2 * (NRM_SQ_STEPS - 1 - k));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sa_v_r[k + 1] <= 1'b0;
      end else begin
        sa_v_r[k + 1] <= sa_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      sa_s_r[k + 1]    <= sa_s_r[k];
      sa_q_r[k + 1][0] <= sqrt_step(sa_q_r[k][0], BITV);
      sa_q_r[k + 1][1] <= sqrt_step(sa_q_r[k][1], BITV);
    end
  end

  // ---------------------------------------------------------------------------------
  // Unit directions: six restoring dividers, one quotient bit per stage.
  // ---------------------------------------------------------------------------------
  logic        da_v_r   [0:NRM_DIV_STEPS];
  logic [63:0] da_rem_r [0:NRM_DIV_STEPS][6];
  logic [30:0] da_q_r   [0:NRM_DIV_STEPS][6];
  da_side_t    da_s_r   [0:NRM_DIV_STEPS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      da_rem_r[0][i] <= 64'(sa_s_r[NRM_SQ_STEPS].nmag[i]) << 30;
      da_q_r[0][i]   <= '0;
    end
    da_s_r[0].p0   <= sa_s_r[NRM_SQ_STEPS].p0;
    da_s_r[0].neg  <= sa_s_r[NRM_SQ_STEPS].neg;
    da_s_r[0].okt  <= sa_s_r[NRM_SQ_STEPS].okt;
    da_s_r[0].okj  <= sa_s_r[NRM_SQ_STEPS].okj;
    da_s_r[0].n[0] <= sa_q_r[NRM_SQ_STEPS][0].r[30:0];
    da_s_r[0].n[1] <= sa_q_r[NRM_SQ_STEPS][1].r[30:0];
  end

  for (genvar k = 0; k < NRM_DIV_STEPS; k++) begin : g_ndiv
    localparam int POS = NRM_DIV_STEPS - 1 - k;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        da_v_r[k + 1] <= 1'b0;
      end else begin
        da_v_r[k + 1] <= da_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      logic [63:0] dvs;
      da_s_r[k + 1] <= da_s_r[k];
      for (int i = 0; i < 6; i++) begin
        dvs = 64'(da_s_r[k].n[i / 3]) << POS;
        if (da_rem_r[k][i] >= dvs) begin
          da_rem_r[k + 1][i] <= da_rem_r[k][i] - dvs;
          da_q_r[k + 1][i]   <= da_q_r[k][i] | (31'(1) << POS);
        end else begin
          da_rem_r[k + 1][i] <= da_rem_r[k][i];
          da_q_r[k + 1][i]   <= da_q_r[k][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Dot products and the numerators and denominator of the 2x2 solve.
  // ---------------------------------------------------------------------------------
  logic                     p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r;
  geo_t                     p1_g_r, p2_g_r, p3_g_r, p4_g_r, p5_g_r, p6_g_r;
  logic                     p1_ok_r, p2_ok_r, p3_ok_r, p4_ok_r;
  logic signed [63:0]       p2_c_r [3];
  logic signed [CB+31:0]    p2_pa_r [3];
  logic signed [CB+31:0]    p2_pb_r [3];
  logic signed [31:0]       p3_c30_r;
  logic signed [AW-1:0]     p3_a8_r, p3_b8_r;
  logic signed [63:0]       p4_c2_r;
  logic signed [31+AW:0]    p4_ca_r, p4_cb_r;
  logic signed [AW-1:0]     p4_a8_r, p4_b8_r;
  logic [30:0]              p5_den_r, p6_den_r;
  logic signed [NW-1:0]     p5_nu_r, p5_nt_r;
  logic                     p5_deg_r, p6_deg_r;
  logic [NW-1:0]            p6_mu_r, p6_mt_r;
  logic [1:0]               p6_neg_r;
  logic signed [63:0]       c60_c;
  logic signed [33:0]       c34_c;
  logic signed [AW-1:0]     a8_c, b8_c;
  logic [60:0]              den60_c;
  logic [30:0]              den_c;

  always_comb begin
    c60_c = p2_c_r[0] + p2_c_r[1] + p2_c_r[2];
    c34_c = c60_c[63:30];
    a8_c  = '0;
    b8_c  = '0;
    for (int i = 0; i < 3; i++) begin
      a8_c = a8_c + AW'($signed(p2_pa_r[i][CB+31:30]));
      b8_c = b8_c + AW'($signed(p2_pb_r[i][CB+31:30]));
    end
    den60_c = (61'(1) << 60) - p4_c2_r[60:0];
    den_c   = den60_c[60:30];
  end

  always_ff @(posedge clk) begin
    logic [30:0] qv;
    // Direction components, capped at one and signed.
    p1_g_r.p0 <= da_s_r[NRM_DIV_STEPS].p0;
    for (int i = 0; i < 6; i++) begin
      qv = (da_q_r[NRM_DIV_STEPS][i] > 31'h4000_0000) ? 31'h4000_0000 :
           da_q_r[NRM_DIV_STEPS][i];
      if (i < 3) begin
        p1_g_r.dt[i] <= da_s_r[NRM_DIV_STEPS].neg[i] ? -32'(qv) : 32'(qv);
      end else begin
        p1_g_r.dj[i - 3] <= da_s_r[NRM_DIV_STEPS].neg[i] ? -32'(qv) : 32'(qv);
      end
    end
    p1_ok_r <= da_s_r[NRM_DIV_STEPS].okt & da_s_r[NRM_DIV_STEPS].okj;

    for (int i = 0; i < 3; i++) begin
      p2_c_r[i]  <= $signed(p1_g_r.dt[i]) * $signed(p1_g_r.dj[i]);
      p2_pa_r[i] <= $signed(p1_g_r.p0[i]) * $signed(p1_g_r.dt[i]);
      p2_pb_r[i] <= $signed(p1_g_r.p0[i]) * $signed(p1_g_r.dj[i]);
    end
    p2_g_r  <= p1_g_r;
    p2_ok_r <= p1_ok_r;

    if (c34_c > 34'sd1073741824) begin
      p3_c30_r <= 32'sd1073741824;
    end else if (c34_c < -34'sd1073741824) begin
      p3_c30_r <= -32'sd1073741824;
    end else begin
      p3_c30_r <= c34_c[31:0];
    end
    p3_a8_r <= a8_c;
    p3_b8_r <= b8_c;
    p3_g_r  <= p2_g_r;
    p3_ok_r <= p2_ok_r;

    p4_c2_r <= p3_c30_r * p3_c30_r;
    p4_ca_r <= p3_c30_r * p3_a8_r;
    p4_cb_r <= p3_c30_r * p3_b8_r;
    p4_a8_r <= p3_a8_r;
    p4_b8_r <= p3_b8_r;
    p4_g_r  <= p3_g_r;
    p4_ok_r <= p3_ok_r;

    p5_den_r <= den_c;
    p5_nu_r  <= (NW'(p4_b8_r) <<< 30) - NW'(p4_ca_r);
    p5_nt_r  <= NW'(p4_cb_r) - (NW'(p4_a8_r) <<< 30);
    p5_deg_r <= !p4_ok_r || (den_c == '0) || (den_c < cfg_limit_r);
    p5_g_r   <= p4_g_r;

    p6_mu_r  <= p5_nu_r[NW-1] ? NW'(-p5_nu_r) : NW'(p5_nu_r);
    p6_mt_r  <= p5_nt_r[NW-1] ? NW'(-p5_nt_r) : NW'(p5_nt_r);
    p6_neg_r <= {p5_nt_r[NW-1], p5_nu_r[NW-1]};
    p6_den_r <= p5_den_r;
    p6_deg_r <= p5_deg_r;
    p6_g_r   <= p5_g_r;
  end

  // ---------------------------------------------------------------------------------
  // Line parameters u and t: two restoring dividers with a saturation check up front.
  // ---------------------------------------------------------------------------------
  logic           db_v_r   [0:PAR_DIV_STEPS];
  logic [PDW-1:0] db_rem_r [0:PAR_DIV_STEPS][2];
  logic [31:0]    db_q_r   [0:PAR_DIV_STEPS][2];
  db_side_t       db_s_r   [0:PAR_DIV_STEPS];

  always_ff @(posedge clk) begin
    db_rem_r[0][0]  <= PDW'(p6_mu_r);
    db_rem_r[0][1]  <= PDW'(p6_mt_r);
    db_q_r[0][0]    <= '0;
    db_q_r[0][1]    <= '0;
    db_s_r[0].geo   <= p6_g_r;
    db_s_r[0].deg   <= p6_deg_r;
    db_s_r[0].den   <= p6_den_r;
    db_s_r[0].neg   <= p6_neg_r;
    db_s_r[0].ovf_u <= PDW'(p6_mu_r) >= (PDW'(p6_den_r) << 32);
    db_s_r[0].ovf_t <= PDW'(p6_mt_r) >= (PDW'(p6_den_r) << 32);
  end

  for (genvar k = 0; k < PAR_DIV_STEPS; k++) begin : g_pdiv
    localparam int POS = PAR_DIV_STEPS - 1 - k;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        db_v_r[k + 1] <= 1'b0;
      end else begin
        db_v_r[k + 1] <= db_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      logic [PDW-1:0] dvs;
      db_s_r[k + 1] <= db_s_r[k];
      dvs = PDW'(db_s_r[k].den) << POS;
      for (int i = 0; i < 2; i++) begin
        if (db_rem_r[k][i] >= dvs) begin
          db_rem_r[k + 1][i] <= db_rem_r[k][i] - dvs;
          db_q_r[k + 1][i]   <= db_q_r[k][i] | (32'(1) << POS);
        end else begin
          db_rem_r[k + 1][i] <= db_rem_r[k][i];
          db_q_r[k + 1][i]   <= db_q_r[k][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Closest points, their difference and its squares.
  // ---------------------------------------------------------------------------------
  logic               r1_v_r, r2_v_r, r3_v_r, r4_v_r, r5_v_r;
  geo_t               r1_g_r, r2_g_r;
  logic [2:0][CB-1:0] r3_p0_r, r4_p0_r, r5_p0_r;
  logic               r1_deg_r, r2_deg_r, r3_deg_r, r4_deg_r, r5_deg_r;
  logic signed [33:0] r1_u8_r, r1_t8_r;
  logic signed [65:0] r2_pt_r [3];
  logic signed [65:0] r2_pu_r [3];
  logic signed [36:0] r3_pca_r [3];
  logic signed [35:0] r3_uj_r [3];
  logic signed [37:0] r4_diff_r [3];
  logic [2:0][31:0]   r4_sat_r, r5_sat_r;
  logic               r4_far_r, r5_far_r;
  logic [61:0]        r5_sq_r [3];
  logic [32:0]        val_u_c, val_t_c;
  logic signed [37:0] diff_c [3];
  logic [2:0]         far_c;

  always_comb begin
    val_u_c = db_s_r[PAR_DIV_STEPS].ovf_u ? 33'h1_0000_0000 :
              33'(db_q_r[PAR_DIV_STEPS][0]);
    val_t_c = db_s_r[PAR_DIV_STEPS].ovf_t ? 33'h1_0000_0000 :
              33'(db_q_r[PAR_DIV_STEPS][1]);
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = 38'(r3_uj_r[i]) - 38'(r3_pca_r[i]);
      // Far when the difference does not fit strictly inside (-2^31, 2^31).
      far_c[i]  = !((diff_c[i][37:31] == '0) || (diff_c[i][37:31] == '1)) ||
                  ((diff_c[i][37:31] == '1) && (diff_c[i][30:0] == '0));
    end
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] d32;
    r1_u8_r  <= db_s_r[PAR_DIV_STEPS].neg[0] ? -34'(val_u_c) : 34'(val_u_c);
    r1_t8_r  <= db_s_r[PAR_DIV_STEPS].neg[1] ? -34'(val_t_c) : 34'(val_t_c);
    r1_g_r   <= db_s_r[PAR_DIV_STEPS].geo;
    r1_deg_r <= db_s_r[PAR_DIV_STEPS].deg;

    for (int i = 0; i < 3; i++) begin
      r2_pt_r[i] <= r1_t8_r * $signed(r1_g_r.dt[i]);
      r2_pu_r[i] <= r1_u8_r * $signed(r1_g_r.dj[i]);
    end
    r2_g_r   <= r1_g_r;
    r2_deg_r <= r1_deg_r;

    for (int i = 0; i < 3; i++) begin
      r3_pca_r[i] <= 37'($signed(r2_g_r.p0[i])) + 37'($signed(r2_pt_r[i][65:30]));
      r3_uj_r[i]  <= r2_pu_r[i][65:30];
    end
    r3_p0_r  <= r2_g_r.p0;
    r3_deg_r <= r2_deg_r;

    for (int i = 0; i < 3; i++) begin
      r4_diff_r[i] <= diff_c[i];
      if ((r3_pca_r[i][36:31] == '0) || (r3_pca_r[i][36:31] == '1)) begin
        r4_sat_r[i] <= r3_pca_r[i][31:0];
      end else begin
        r4_sat_r[i] <= r3_pca_r[i][36] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
    r4_far_r <= |far_c;
    r4_p0_r  <= r3_p0_r;
    r4_deg_r <= r3_deg_r;

    for (int i = 0; i < 3; i++) begin
      d32        = r4_diff_r[i][31:0];
      r5_sq_r[i] <= 62'(64'(d32) * 64'(d32));
    end
    r5_sat_r <= r4_sat_r;
    r5_far_r <= r4_far_r;
    r5_p0_r  <= r4_p0_r;
    r5_deg_r <= r4_deg_r;
  end

  // ---------------------------------------------------------------------------------
  // Distance: square root of the summed squares, one root bit per stage.
  // ---------------------------------------------------------------------------------
  logic     sd_v_r [0:DST_SQ_STEPS];
  sqrt_t    sd_q_r [0:DST_SQ_STEPS];
  sd_side_t sd_s_r [0:DST_SQ_STEPS];

  always_ff @(posedge clk) begin
    sd_q_r[0].x   <= 64'(r5_sq_r[0]) + 64'(r5_sq_r[1]) + 64'(r5_sq_r[2]);
    sd_q_r[0].r   <= '0;
    sd_s_r[0].p0  <= r5_p0_r;
    sd_s_r[0].pca <= r5_sat_r;
    sd_s_r[0].far <= r5_far_r;
    sd_s_r[0].deg <= r5_deg_r;
  end

  for (genvar k = 0; k < DST_SQ_STEPS; k++) begin : g_dsq
    localparam logic [63:0] BITV = 64'(1) << (2 * (DST_SQ_STEPS - 1 - k));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_v_r[k + 1] <= 1'b0;
      end else begin
        sd_v_r[k + 1] <= sd_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      sd_s_r[k + 1] <= sd_s_r[k];
      sd_q_r[k + 1] <= sqrt_step(sd_q_r[k], BITV);
    end
  end

  // ---------------------------------------------------------------------------------
  // Valid bits of the plain stages and the section entries.
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      sa_v_r[0] <= 1'b0;
      da_v_r[0] <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      p3_v_r    <= 1'b0;
      p4_v_r    <= 1'b0;
      p5_v_r    <= 1'b0;
      p6_v_r    <= 1'b0;
      db_v_r[0] <= 1'b0;
      r1_v_r    <= 1'b0;
      r2_v_r    <= 1'b0;
      r3_v_r    <= 1'b0;
      r4_v_r    <= 1'b0;
      r5_v_r    <= 1'b0;
      sd_v_r[0] <= 1'b0;
    end else begin
      s1_v_r    <= start & ~busy;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      sa_v_r[0] <= s4_v_r;
      da_v_r[0] <= sa_v_r[NRM_SQ_STEPS];
      p1_v_r    <= da_v_r[NRM_DIV_STEPS];
      p2_v_r    <= p1_v_r;
      p3_v_r    <= p2_v_r;
      p4_v_r    <= p3_v_r;
      p5_v_r    <= p4_v_r;
      p6_v_r    <= p5_v_r;
      db_v_r[0] <= p6_v_r;
      r1_v_r    <= db_v_r[PAR_DIV_STEPS];
      r2_v_r    <= r1_v_r;
      r3_v_r    <= r2_v_r;
      r4_v_r    <= r3_v_r;
      r5_v_r    <= r4_v_r;
      sd_v_r[0] <= r5_v_r;
    end
  end

  // ---------------------------------------------------------------------------------
  // Result register. A degenerate beat reports the first point and zero distance.
  // ---------------------------------------------------------------------------------
  sd_side_t sd_last;
  assign sd_last = sd_s_r[DST_SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= sd_v_r[DST_SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (sd_last.deg) begin
      out_pca_x        <= OUT_BITS'($signed(sd_last.p0[0]));
      out_pca_y        <= OUT_BITS'($signed(sd_last.p0[1]));
      out_pca_z        <= OUT_BITS'($signed(sd_last.p0[2]));
      out_min_distance <= '0;
      out_degenerate   <= 1'b1;
    end else begin
      out_pca_x <= sd_last.pca[0];
      out_pca_y <= sd_last.pca[1];
      out_pca_z <= sd_last.pca[2];
      if (sd_last.far || (sd_q_r[DST_SQ_STEPS].r > 64'h7fff_ffff)) begin
        out_min_distance <= '1;
      end else begin
        out_min_distance <= sd_q_r[DST_SQ_STEPS].r[DIST_BITS-1:0];
      end
      out_degenerate <= 1'b0;
    end
  end

endmodule

### rtl/core/tjca_checker.sv
// Port-level checks on the closest approach block, bound to its top level.
module tjca_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic signed [tjca_pkg::COORD_BITS-1:0] in_first_x,
  input logic signed [tjca_pkg::COORD_BITS-1:0] in_first_z,
  input logic                                out_strobe,
  input logic signed [tjca_pkg::OUT_BITS-1:0] out_pca_x,
  input logic signed [tjca_pkg::OUT_BITS-1:0] out_pca_z,
  input logic [tjca_pkg::DIST_BITS-1:0]      out_min_distance,
  input logic                                out_degenerate
);
  import tjca_pkg::*;

  // Every accepted beat returns exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TJCA_LATENCY out_strobe)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TJCA_LATENCY))
    else $error("result without an accepted beat");

  a_deg_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_degenerate) |-> (out_min_distance == '0))
    else $error("degenerate result with nonzero distance");

  a_deg_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_degenerate) |->
      ((out_pca_x == OUT_BITS'($past(in_first_x, TJCA_LATENCY))) &&
       (out_pca_z == OUT_BITS'($past(in_first_z, TJCA_LATENCY)))))
    else $error("degenerate result does not report the first point");

endmodule

bind track_jet_closest_approach_top tjca_checker u_tjca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_first_x       (in_first_x),
  .in_first_z       (in_first_z),
  .out_strobe       (out_strobe),
  .out_pca_x        (out_pca_x),
  .out_pca_z        (out_pca_z),
  .out_min_distance (out_min_distance),
  .out_degenerate   (out_degenerate)
);

### test/track_jet_closest_approach_top_tb.sv
// Testbench for the track and jet closest approach pipeline, with its own bit-exact predictor.
`timescale 1ns / 100ps

module track_jet_closest_approach_top_tb;
  import tjca_pkg::*;

  localparam longint ONE_Q30   = longint'(1) << 30;
  localparam longint T_LIMIT   = longint'(1) << 32;
  localparam longint DIST_CAP  = 64'h7FFF_FFFF;
  localparam longint LIMIT_MAX = longint'(1) << 30;

  typedef longint vec3_t [0:2];

  // One beat on the input channel: both track points and the jet momentum.
  typedef struct {
    logic signed [COORD_BITS-1:0] first [0:2];
    logic signed [COORD_BITS-1:0] last  [0:2];
    logic signed [COORD_BITS-1:0] jet   [0:2];
  } track_jet_t;

  // One beat on the result channel.
  typedef struct {
    logic signed [OUT_BITS-1:0] pca [0:2];
    logic [DIST_BITS-1:0]       distance;
    logic                       degenerate;
  } approach_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_BITS-1:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic signed [COORD_BITS-1:0] in_last_x = '0, in_last_y = '0, in_last_z = '0;
  logic signed [COORD_BITS-1:0] in_jet_px = '0, in_jet_py = '0, in_jet_pz = '0;
  logic cfg_we = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic signed [OUT_BITS-1:0] out_pca_x, out_pca_y, out_pca_z;
  logic [DIST_BITS-1:0] out_min_distance;
  logic out_degenerate;

  track_jet_closest_approach_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_last_x(in_last_x), .in_last_y(in_last_y), .in_last_z(in_last_z),
    .in_jet_px(in_jet_px), .in_jet_py(in_jet_py), .in_jet_pz(in_jet_pz),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe),
    .out_pca_x(out_pca_x), .out_pca_y(out_pca_y), .out_pca_z(out_pca_z),
    .out_min_distance(out_min_distance), .out_degenerate(out_degenerate)
  );

  // The clock runs with a 12 ns period.
  always #6 clk = ~clk;

  // Shadow copy of the parallel limit register, updated whenever the test writes it.
  logic [LIMIT_BITS-1:0] limit_shadow = 31'd1;

  // Expected approaches, oldest first.
  approach_t expected_approaches [$];

  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int degenerate_seen = 0;
  int far_seen = 0;
  int burst_left = 0;

  // Integer square root, digit by digit, floor of the true root.
  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Normalizes a direction to Q1.30; returns zero when the vector is zero.
  function automatic bit unit_direction(input vec3_t v, output vec3_t u);
    bit [63:0] mag [0:2];
    bit [63:0] m;
    bit [63:0] sum;
    bit [63:0] n;
    bit [63:0] q;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 30) / n;
      if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Works out the closest approach that the block should report for one beat.
  function automatic approach_t predict_approach(track_jet_t it, logic [LIMIT_BITS-1:0] lim);
    approach_t r;
    vec3_t p0, d, jv, dt, dj, pca, diff;
    longint c60, c30, den30, a8, b8, nu, nt, u8, t8;
    bit [63:0] den60, s, dist_val;
    bit okt, okj, far;
    c60 = 0;
    a8 = 0;
    b8 = 0;
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p0[i] = longint'(it.first[i]);
      d[i] = longint'(it.last[i]) - p0[i];
      jv[i] = longint'(it.jet[i]);
    end
    okt = unit_direction(d, dt);
    okj = unit_direction(jv, dj);
    for (int i = 0; i < 3; i++) c60 += dt[i] * dj[i];
    c30 = c60 >>> 30;
    if (c30 > ONE_Q30) c30 = ONE_Q30;
    if (c30 < -ONE_Q30) c30 = -ONE_Q30;
    den60 = (64'd1 << 60) - 64'(c30 * c30);
    den30 = longint'(den60 >> 30);
    // Zero directions, exactly parallel lines and lines under the limit all degenerate.
    if (!okt || !okj || den30 == 0 || den30 < longint'(lim)) begin
      for (int i = 0; i < 3; i++) r.pca[i] = OUT_BITS'(p0[i]);
      r.distance = '0;
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      a8 += (p0[i] * dt[i]) >>> 30;
      b8 += (p0[i] * dj[i]) >>> 30;
    end
    nu = b8 * ONE_Q30 - c30 * a8;
    nt = c30 * b8 - a8 * ONE_Q30;
    u8 = nu / den30;
    t8 = nt / den30;
    if (u8 > T_LIMIT) u8 = T_LIMIT;
    if (u8 < -T_LIMIT) u8 = -T_LIMIT;
    if (t8 > T_LIMIT) t8 = T_LIMIT;
    if (t8 < -T_LIMIT) t8 = -T_LIMIT;
    for (int i = 0; i < 3; i++) begin
      pca[i] = p0[i] + ((t8 * dt[i]) >>> 30);
      diff[i] = ((u8 * dj[i]) >>> 30) - pca[i];
      if (diff[i] >= (longint'(1) << 31) || diff[i] <= -(longint'(1) << 31)) far = 1'b1;
      if (pca[i] > 64'sh7FFF_FFFF) r.pca[i] = 32'h7FFF_FFFF;
      else if (pca[i] < -(longint'(1) << 31)) r.pca[i] = 32'h8000_0000;
      else r.pca[i] = OUT_BITS'(pca[i]);
    end
    if (far) begin
      dist_val = 64'(DIST_CAP);
    end else begin
      s = 0;
      for (int i = 0; i < 3; i++) s += 64'(diff[i] * diff[i]);
      dist_val = int_sqrt(s);
      if (dist_val > 64'(DIST_CAP)) dist_val = 64'(DIST_CAP);
    end
    r.distance = DIST_BITS'(dist_val);
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_field(string name, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, name, want, got);
  endtask

  // Every strobe is compared with the oldest expectation; values are read before the edge
  // updates them, so the check sees the beat that this edge takes.
  always @(posedge clk) begin
    approach_t want;
    if (rst_n && out_strobe) begin
      if (expected_approaches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        want = expected_approaches.pop_front();
        if (out_pca_x !== want.pca[0]) report_field("pca_x", want.pca[0], out_pca_x);
        if (out_pca_y !== want.pca[1]) report_field("pca_y", want.pca[1], out_pca_y);
        if (out_pca_z !== want.pca[2]) report_field("pca_z", want.pca[2], out_pca_z);
        if (out_min_distance !== want.distance)
          report_field("min_distance", want.distance, out_min_distance);
        if (out_degenerate !== want.degenerate)
          report_field("degenerate", want.degenerate, out_degenerate);
        if (want.degenerate) degenerate_seen++;
        if (want.distance == DIST_BITS'(DIST_CAP)) far_seen++;
      end
      results_seen++;
    end
  end

  // Sends one beat. The sender works in bursts; between bursts start drops for a random
  // gap, and now and then a burst is long enough to run without any gap at all.
  task automatic send_beat(track_jet_t it);
    if (burst_left == 0) begin
      if (start) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_first_x <= it.first[0];
    in_first_y <= it.first[1];
    in_first_z <= it.first[2];
    in_last_x <= it.last[0];
    in_last_y <= it.last[1];
    in_last_z <= it.last[2];
    in_jet_px <= it.jet[0];
    in_jet_py <= it.jet[1];
    in_jet_pz <= it.jet[2];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_approaches.push_back(predict_approach(it, limit_shadow));
    beats_sent++;
    burst_left--;
  endtask

  // Lets the pipeline empty out, plus its latency, so the register can be written safely.
  task automatic drain_pipeline();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_approaches.size() != 0) @(posedge clk);
    repeat (TJCA_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_parallel_limit(logic [LIMIT_BITS-1:0] value);
    drain_pipeline();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = value;
  endtask

  // A coordinate that is mostly uniform over the full range, with small values and
  // the two extremes mixed in.
  function automatic logic signed [COORD_BITS-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(COORD_BITS-1){1'b1}}};
      1: return {1'b1, {(COORD_BITS-1){1'b0}}};
      2, 3: return COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic track_jet_t random_pair();
    track_jet_t it;
    for (int i = 0; i < 3; i++) begin
      it.first[i] = random_coord();
      it.last[i] = random_coord();
      it.jet[i] = random_coord();
    end
    return it;
  endfunction

  // A track whose direction is close to the jet direction, so the lines are nearly or
  // exactly parallel and the line parameters get large.
  function automatic track_jet_t near_parallel_pair();
    track_jet_t it;
    int dir [0:2];
    int k;
    k = $urandom_range(1, 64);
    for (int i = 0; i < 3; i++) begin
      dir[i] = $signed($urandom_range(0, 4000)) - 2000;
      it.first[i] = ($urandom_range(0, 1)) ? random_coord()
                                            : COORD_BITS'($signed($urandom_range(0, 8000)) - 4000);
      it.last[i] = it.first[i] + COORD_BITS'(dir[i]);
      it.jet[i] = COORD_BITS'(dir[i] * k + (($urandom_range(0, 2) == 0) ?
                                             $signed($urandom_range(0, 2)) - 1 : 0));
    end
    return it;
  endfunction

  function automatic track_jet_t make_pair(int fx, int fy, int fz, int lx, int ly, int lz,
                                           int jx, int jy, int jz);
    track_jet_t it;
    it.first[0] = COORD_BITS'(fx);
    it.first[1] = COORD_BITS'(fy);
    it.first[2] = COORD_BITS'(fz);
    it.last[0] = COORD_BITS'(lx);
    it.last[1] = COORD_BITS'(ly);
    it.last[2] = COORD_BITS'(lz);
    it.jet[0] = COORD_BITS'(jx);
    it.jet[1] = COORD_BITS'(jy);
    it.jet[2] = COORD_BITS'(jz);
    return it;
  endfunction

  // Directed beats: field extremes, zero directions, parallel, perpendicular and far lines.
  task automatic test_directed_cases();
    int hi, lo;
    hi = 8388607;
    lo = -8388608;
    send_beat(make_pair(256, 0, 0, 256, 256, 0, 0, 0, 256));
    send_beat(make_pair(100, 200, 300, 100, 200, 300, 5, 6, 7));
    send_beat(make_pair(100, 200, 300, 400, 500, 600, 0, 0, 0));
    send_beat(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_pair(10, 20, 30, 11, 22, 33, 1, 2, 3));
    send_beat(make_pair(10, 20, 30, 9, 18, 27, 1, 2, 3));
    send_beat(make_pair(hi, hi, hi, lo, lo, lo, hi, hi, hi));
    send_beat(make_pair(lo, lo, lo, hi, hi, hi, lo, lo, lo));
    send_beat(make_pair(lo, hi, lo, hi, lo, hi, hi, lo, 1));
    send_beat(make_pair(hi, lo, 0, hi, lo, 1, lo, lo, lo));
    send_beat(make_pair(hi, hi, hi, hi, hi, lo, 1, 0, 0));
    send_beat(make_pair(lo, 0, 0, lo, 1, 0, hi, 0, 0));
    send_beat(make_pair(hi, 0, hi, hi - 1, 1, hi, 1000, 1001, 0));
    send_beat(make_pair(lo, lo, hi, lo + 3000, lo + 2999, hi, 3000, 3000, 1));
    send_beat(make_pair(0, hi, 0, 1, hi, 0, 0, 0, lo));
    send_beat(make_pair(-1, -1, -1, 1, 1, 1, -1, 1, 0));
    send_beat(make_pair(hi, hi, hi, hi - 1, hi - 1, hi - 1, lo, lo, lo + 1));
    send_beat(make_pair(5000, -7000, 9000, 5001, -7000, 9000, 0, lo, 1));
  endtask

  task automatic test_random_pairs(int count);
    repeat (count) send_beat(random_pair());
  endtask

  task automatic test_mixed_pairs(int count);
    repeat (count) send_beat(($urandom_range(0, 2) == 0) ? near_parallel_pair() : random_pair());
  endtask

  // The run: directed beats at the reset limit, then random beats under each of several
  // limit settings, the extremes 0 and 2^30 among them.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_pairs(350);
    write_parallel_limit(31'd0);
    test_directed_cases();
    test_mixed_pairs(300);
    write_parallel_limit(31'(LIMIT_MAX));
    test_directed_cases();
    test_mixed_pairs(200);
    write_parallel_limit(31'($urandom_range(1, 1 << 20)));
    test_mixed_pairs(300);
    write_parallel_limit(31'($urandom_range(1 << 20, 1 << 30)));
    test_mixed_pairs(200);
    drain_pipeline();
    $display("Sent %0d beats under five limit settings; %0d results checked, %0d degenerate,",
             beats_sent, results_seen, degenerate_seen);
    $display("%0d with saturated distance, %0d mismatches.", far_seen, mismatches);
    if (mismatches == 0 && expected_approaches.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung pipeline: far beyond the slowest correct run.
  initial begin
    #(8_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
